// ===== rtl/core/acs_pkg.sv =====
// Shared constants, types and arithmetic helpers of the autocorrelation
// chi-squared unit. No dependencies.
package acs_pkg;

   localparam int TAPS     = 64;
   localparam int CHANNELS = 4;
   localparam int TAP_W    = 6;
   localparam int CH_W     = 2;
   localparam int ADDR_W   = CH_W + TAP_W;
   localparam int DEPTH    = CHANNELS * TAPS;
   localparam int DATA_W   = 24;
   localparam int COEF_W   = 18;
   localparam int NORM_W   = 42;
   localparam int SUM_W    = 64;
   localparam int Q_W      = 32;
   localparam int CFG_W    = 48;
   localparam int LAT_W    = 7;
   localparam int FILL_W   = TAP_W + 1;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   localparam logic REG_THRESH = 1'b0;
   localparam logic REG_LAT    = 1'b1;

   localparam logic signed [COEF_W-1:0] COEF_MAX = 18'sd131071;
   localparam logic signed [COEF_W-1:0] COEF_MIN = -18'sd131072;

   typedef struct packed {
      logic                     kind;
      logic [CH_W-1:0]          channel;
      logic [TAP_W-1:0]         tap;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic                     mask_bit;
      logic                     restart;
   } acs_item_type;

   typedef struct packed {
      logic [CFG_W-1:0]        thresh;
      logic signed [LAT_W-1:0] lat;
   } acs_cfg_type;

   function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [DATA_W-1:0] v);
      logic signed [COEF_W-1:0] r;
      if (v > DATA_W'(COEF_MAX)) r = COEF_MAX;
      else if (v < DATA_W'(COEF_MIN)) r = COEF_MIN;
      else r = v[COEF_W-1:0];
      return r;
   endfunction

   // Norm contribution of one tap: 2.0 - |A|^2 in Q.32.
   function automatic logic signed [NORM_W-1:0] norm_term(input logic signed [COEF_W-1:0] re,
                                                          input logic signed [COEF_W-1:0] im);
      logic signed [NORM_W-1:0] sq;
      sq = NORM_W'(re * re) + NORM_W'(im * im);
      return (NORM_W'(2) <<< 32) - sq;
   endfunction

endpackage

// ===== rtl/core/acs_if.sv =====
// Request and response channel interfaces of the autocorrelation chi-squared unit.
// Depends on acs_pkg for field widths.
interface acs_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      operation;
   logic [acs_pkg::CH_W-1:0]                  channel;
   logic [acs_pkg::TAP_W-1:0]                 tap_index;
   logic signed [acs_pkg::DATA_W-1:0]         value_re;
   logic signed [acs_pkg::DATA_W-1:0]         value_im;
   logic                                      mask_bit;
   logic                                      restart;
   modport source(output valid, operation, channel, tap_index, value_re, value_im,
                  mask_bit, restart, input ready);
   modport sink(input valid, operation, channel, tap_index, value_re, value_im,
                mask_bit, restart, output ready);
endinterface

interface acs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [acs_pkg::CH_W-1:0]     out_channel;
   logic [acs_pkg::Q_W-1:0]      chisq;
   logic                         below_threshold;
   logic                         saturated;
   modport source(output valid, out_channel, chisq, below_threshold, saturated,
                  input ready);
   modport sink(input valid, out_channel, chisq, below_threshold, saturated,
                output ready);
endinterface

// ===== rtl/core/acs_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on acs_pkg and acs_req_if.
module acs_front (
   input  logic                 clock,
   input  logic                 reset,
   acs_req_if.sink              req_chan,
   output logic                 q_valid,
   output acs_pkg::acs_item_type q_item,
   input  logic                 q_ready
);
   import acs_pkg::*;

   acs_item_type slot_ff [2];
   logic [1:0]   count_ff;
   logic         keep;
   logic         push;
   logic         pop;
   acs_item_type item_in;

   // Out-of-range channels and taps never reach the back end.
   always_comb begin
      item_in.kind     = req_chan.operation ? KIND_COEF : KIND_SAMPLE;
      item_in.channel  = req_chan.channel;
      item_in.tap      = req_chan.tap_index;
      item_in.re       = req_chan.value_re;
      item_in.im       = req_chan.value_im;
      item_in.mask_bit = req_chan.mask_bit;
      item_in.restart  = req_chan.restart;
      keep = (32'(req_chan.channel) < CHANNELS) &&
             (!req_chan.operation || (32'(req_chan.tap_index) < TAPS));
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push    = req_chan.valid && req_chan.ready && keep;
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = slot_ff[0];
   assign pop     = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (pop) begin
         slot_ff[0] <= (count_ff == 2'd2) ? slot_ff[1] : item_in;
         if (count_ff == 2'd2 && push) slot_ff[1] <= item_in;
      end else if (push) begin
         if (count_ff == 2'd0) slot_ff[0] <= item_in;
         else slot_ff[1] <= item_in;
      end
   end
endmodule

// ===== rtl/core/acs_back.sv =====
// Back end: sample windows, coefficient table, norms, the tap sequencer with its
// multiply pipeline, a bit-serial divider and the response register. Uses acs_pkg.
module acs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  acs_pkg::acs_item_type q_item,
   output logic                  q_ready,
   input  acs_pkg::acs_cfg_type  cfg,
   acs_rsp_if.source             rsp_chan
);
   import acs_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CW1  = 4'd1;
   localparam logic [3:0] ST_CW2  = 4'd2;
   localparam logic [3:0] ST_CW3  = 4'd3;
   localparam logic [3:0] ST_SWR  = 4'd4;
   localparam logic [3:0] ST_SREF = 4'd5;
   localparam logic [3:0] ST_SMAG = 4'd6;
   localparam logic [3:0] ST_STHR = 4'd7;
   localparam logic [3:0] ST_LOOP = 4'd8;
   localparam logic [3:0] ST_DINI = 4'd9;
   localparam logic [3:0] ST_DIV  = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   localparam int PIPE = 4;
   localparam logic [FILL_W:0] LOOP_END = (FILL_W + 1)'(TAPS + PIPE - 1);

   // Memories.
   logic [2*DATA_W-1:0]          wmem [DEPTH];
   logic [2*COEF_W:0]            cmem [DEPTH];
   logic [DEPTH-1:0]             cvalid_ff;
   logic [2*DATA_W-1:0]          wrd_ff;
   logic [2*COEF_W:0]            crd_ff;
   logic                         cvrd_ff;
   logic [ADDR_W-1:0]            waddr, wraddr, craddr;
   logic                         wwe, cwe;

   // Control and per-channel state.
   logic [3:0]                   state_ff, state_in;
   acs_item_type                 it_ff;
   logic signed [NORM_W-1:0]     norm_ff [CHANNELS];
   logic [FILL_W-1:0]            fill_ff [CHANNELS];
   logic [TAP_W-1:0]             head_ff [CHANNELS];
   logic [TAP_W-1:0]             base_ff, ref_ff;
   logic signed [NORM_W-1:0]     term_ff;
   logic [FILL_W:0]              cnt_ff;
   logic signed [DATA_W-1:0]     sre_ff, sim_ff;
   logic [CFG_W-1:0]             mag_ff;
   logic [SUM_W-1:0]             sum_ff;
   logic [NORM_W:0]              rem_ff;
   logic [Q_W-1:0]               dlo_ff, quo_ff;
   logic [4:0]                   dcnt_ff;
   logic                         below_ff, sat_ff;

   // Tap pipeline.
   logic                         v0_ff, v1_ff, v2_ff, v3_ff;
   logic                         m1_ff, m2_ff, m3_ff;
   logic signed [COEF_W+DATA_W-1:0] prr_ff, pii_ff, pri_ff, pir_ff;
   logic signed [DATA_W-1:0]     xre1_ff, xim1_ff;
   logic signed [29:0]           zre2_ff, zim2_ff;
   logic [59:0]                  sqre3_ff, sqim3_ff;

   logic                         out_valid_ff;
   logic [CH_W-1:0]              out_ch_ff;
   logic [Q_W-1:0]               out_q_ff;
   logic                         out_below_ff, out_sat_ff;

   logic [TAP_W-1:0]             head_now, head_next;
   logic [FILL_W-1:0]            fill_now, fill_next;
   logic signed [LAT_W:0]        lat_c;
   logic [TAP_W-1:0]             lat_off;
   logic                         issue;
   logic signed [COEF_W-1:0]     new_re, new_im;
   logic signed [COEF_W-1:0]     old_re, old_im;
   logic signed [COEF_W-1:0]     are, aim;
   logic signed [45:0]           zre_full, zim_full;
   logic [NORM_W+1:0]            rtry;
   logic                         norm_pos;

   assign new_re = sat_coef(it_ff.re);
   assign new_im = sat_coef(it_ff.im);
   assign old_re = crd_ff[COEF_W-1:0];
   assign old_im = crd_ff[2*COEF_W-1:COEF_W];
   assign are    = cvrd_ff ? crd_ff[COEF_W-1:0] : '0;
   assign aim    = cvrd_ff ? crd_ff[2*COEF_W-1:COEF_W] : '0;

   always_comb begin
      head_now  = it_ff.restart ? '0 : head_ff[it_ff.channel];
      fill_now  = it_ff.restart ? '0 : fill_ff[it_ff.channel];
      head_next = head_now + 1'b1;
      fill_next = (32'(fill_now) < TAPS) ? fill_now + 1'b1 : fill_now;
      if (cfg.lat > 0) lat_c = '0;
      else if (cfg.lat < -(LAT_W + 1)'(TAPS - 1)) lat_c = -(LAT_W + 1)'(TAPS - 1);
      else lat_c = (LAT_W + 1)'(cfg.lat);
      lat_off = TAP_W'((LAT_W + 1)'(TAPS - 1) + lat_c);
      issue   = (state_ff == ST_LOOP) && (32'(cnt_ff) < TAPS);
      wwe     = (state_ff == ST_SWR);
      waddr   = {it_ff.channel, head_now};
      wraddr  = (state_ff == ST_SREF) ? {it_ff.channel, ref_ff}
                                      : {it_ff.channel, base_ff + cnt_ff[TAP_W-1:0]};
      craddr  = (state_ff == ST_IDLE) ? {q_item.channel, q_item.tap}
                                      : {it_ff.channel, cnt_ff[TAP_W-1:0]};
      cwe     = (state_ff == ST_CW3);
      // Round half up from Q.28 to Q.12 is an arithmetic shift after adding half.
      zre_full = 46'(prr_ff) - 46'(pii_ff) - (46'(xre1_ff) <<< 16) + 46'sd32768;
      zim_full = 46'(pri_ff) + 46'(pir_ff) - (46'(xim1_ff) <<< 16) + 46'sd32768;
      rtry     = {rem_ff, dlo_ff[Q_W-1]};
      norm_pos = (norm_ff[it_ff.channel] > 0);
   end

   assign q_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) state_in = (q_item.kind == KIND_COEF) ? ST_CW1 : ST_SWR;
         ST_CW1:  state_in = ST_CW2;
         ST_CW2:  state_in = ST_CW3;
         ST_CW3:  state_in = ST_IDLE;
         ST_SWR:  state_in = (32'(fill_next) < TAPS) ? ST_IDLE : ST_SREF;
         ST_SREF: state_in = ST_SMAG;
         ST_SMAG: state_in = ST_STHR;
         ST_STHR: state_in = (mag_ff < cfg.thresh) ? ST_OUT : ST_LOOP;
         ST_LOOP: if (cnt_ff == LOOP_END) state_in = ST_DINI;
         ST_DINI: state_in = (!norm_pos || sum_ff >= (SUM_W'(norm_ff[it_ff.channel]) << 8))
                             ? ST_OUT : ST_DIV;
         ST_DIV:  if (dcnt_ff == 5'd0) state_in = ST_OUT;
         ST_OUT:  if (!out_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wwe) wmem[waddr] <= {it_ff.im, it_ff.re};
      wrd_ff <= wmem[wraddr];
      if (cwe) cmem[{it_ff.channel, it_ff.tap}] <= {it_ff.mask_bit, new_im, new_re};
      crd_ff  <= cmem[craddr];
      cvrd_ff <= cvalid_ff[craddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cvalid_ff    <= '0;
         out_valid_ff <= 1'b0;
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            norm_ff[c] <= '0;
            fill_ff[c] <= '0;
            head_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_chan.ready && state_ff != ST_OUT) out_valid_ff <= 1'b0;
         v0_ff <= issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         case (state_ff)
            ST_IDLE: if (q_valid) it_ff <= q_item;
            ST_CW1: begin
               term_ff <= (cvrd_ff && crd_ff[2*COEF_W]) ? norm_term(old_re, old_im) : '0;
            end
            ST_CW2: begin
               norm_ff[it_ff.channel] <= norm_ff[it_ff.channel] - term_ff;
               term_ff <= it_ff.mask_bit ? norm_term(new_re, new_im) : '0;
            end
            ST_CW3: begin
               norm_ff[it_ff.channel] <= norm_ff[it_ff.channel] + term_ff;
               cvalid_ff[{it_ff.channel, it_ff.tap}] <= 1'b1;
            end
            ST_SWR: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  if (CH_W'(c) == it_ff.channel) begin
                     head_ff[c] <= head_next;
                     fill_ff[c] <= fill_next;
                  end else if (it_ff.restart) begin
                     fill_ff[c] <= '0;
                     head_ff[c] <= '0;
                  end
               end
               base_ff <= head_next;
               ref_ff  <= head_next + lat_off;
            end
            ST_SMAG: begin
               sre_ff <= wrd_ff[DATA_W-1:0];
               sim_ff <= wrd_ff[2*DATA_W-1:DATA_W];
               mag_ff <= CFG_W'($signed(wrd_ff[DATA_W-1:0]) * $signed(wrd_ff[DATA_W-1:0]))
                       + CFG_W'($signed(wrd_ff[2*DATA_W-1:DATA_W])
                                * $signed(wrd_ff[2*DATA_W-1:DATA_W]));
            end
            ST_STHR: begin
               below_ff <= (mag_ff < cfg.thresh);
               sat_ff   <= 1'b0;
               quo_ff   <= '0;
               sum_ff   <= '0;
               cnt_ff   <= '0;
            end
            ST_LOOP: cnt_ff <= cnt_ff + 1'b1;
            ST_DINI: begin
               sat_ff  <= (state_in == ST_OUT);
               rem_ff  <= (NORM_W + 1)'(sum_ff[SUM_W-1:8]);
               dlo_ff  <= {sum_ff[7:0], 24'd0};
               dcnt_ff <= 5'd31;
            end
            ST_DIV: begin
               if (rtry >= (NORM_W + 2)'(norm_ff[it_ff.channel])) begin
                  rem_ff <= (NORM_W + 1)'(rtry - (NORM_W + 2)'(norm_ff[it_ff.channel]));
                  quo_ff <= {quo_ff[Q_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rtry[NORM_W:0];
                  quo_ff <= {quo_ff[Q_W-2:0], 1'b0};
               end
               dlo_ff  <= {dlo_ff[Q_W-2:0], 1'b0};
               dcnt_ff <= dcnt_ff - 1'b1;
            end
            ST_OUT: begin
               if (!out_valid_ff || rsp_chan.ready) begin
                  out_valid_ff <= 1'b1;
                  out_ch_ff    <= it_ff.channel;
                  out_below_ff <= below_ff;
                  out_sat_ff   <= sat_ff;
                  out_q_ff     <= sat_ff ? '1 : quo_ff;
               end
            end
            default: ;
         endcase
         if (v3_ff && m3_ff) sum_ff <= sum_ff + SUM_W'(sqre3_ff) + SUM_W'(sqim3_ff);
      end
      // Tap pipeline payload: products, rounded error, squares.
      prr_ff  <= are * sre_ff;
      pii_ff  <= aim * sim_ff;
      pri_ff  <= are * sim_ff;
      pir_ff  <= aim * sre_ff;
      xre1_ff <= wrd_ff[DATA_W-1:0];
      xim1_ff <= wrd_ff[2*DATA_W-1:DATA_W];
      m1_ff   <= cvrd_ff && crd_ff[2*COEF_W];
      zre2_ff <= 30'(zre_full >>> 16);
      zim2_ff <= 30'(zim_full >>> 16);
      m2_ff   <= m1_ff;
      sqre3_ff <= 60'(zre2_ff * zre2_ff);
      sqim3_ff <= 60'(zim2_ff * zim2_ff);
      m3_ff   <= m2_ff;
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.out_channel     = out_ch_ff;
   assign rsp_chan.chisq           = out_q_ff;
   assign rsp_chan.below_threshold = out_below_ff;
   assign rsp_chan.saturated       = out_sat_ff;
endmodule

// ===== rtl/core/autocorrelation_chisq_unit.sv =====
// Autocorrelation chi-squared consistency test, complex mode, top level.
// Depends on acs_pkg, acs_if, acs_front and acs_back.
//
// Requests arrive on req_chan (valid/ready). A coefficient write updates the
// coefficient table and the channel norm. A sample goes into its channel
// window; once the window holds all taps, it yields one response on rsp_chan.
// A response below threshold skips the sequencer and divider; otherwise the tap
// sequencer reads one coefficient and one windowed sample per cycle through a
// four-stage multiply pipeline, then a bit-serial divider forms the quotient.
// The front queue holds two requests, so up to two requests are taken while
// the back end is busy. The response is held in an output register: a stalled
// receiver keeps it there and stops the back end only when the next response
// is ready. Reset (synchronous, active high) clears the windows' fill counts,
// the norms, the coefficient table and the configuration registers at once.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, since the block does not enforce this.
module autocorrelation_chisq_unit (
   input  logic                        clock,
   input  logic                        reset,
   acs_req_if.sink                     req_chan,
   acs_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [acs_pkg::CFG_W-1:0]   csr_wdata
);
   import acs_pkg::*;

   acs_cfg_type  cfg_ff;
   logic         q_valid, q_ready;
   acs_item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_THRESH: cfg_ff.thresh <= csr_wdata;
            REG_LAT:    cfg_ff.lat    <= csr_wdata[LAT_W-1:0];
            default: ;
         endcase
      end
   end

   acs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_ready  (q_ready)
   );

   acs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_ready  (q_ready),
      .cfg      (cfg_ff),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.below_threshold && rsp_chan.saturated))
      else $error("below_threshold and saturated both set");
   a_below_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.below_threshold) |-> (rsp_chan.chisq == '0))
      else $error("below threshold response with nonzero chisq");
   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.saturated) |-> (rsp_chan.chisq == '1))
      else $error("saturated response without full-scale chisq");
`endif
endmodule
